// ===== design/json_value_extent_scanner_assert.svh =====
// assertion macros for the json value extent scanner checker
// expects signals named clk and rst in the scope of each use
`ifndef JSON_VALUE_EXTENT_SCANNER_ASSERT_SVH
`define JSON_VALUE_EXTENT_SCANNER_ASSERT_SVH

// checked only outside reset
`define JVES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define JVES_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/jves_pkg.sv =====
// shared constants and helpers for the json value extent scanner
// no dependencies
package jves_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int MAX_DEPTH   = 255;

  // offset register width: the length limit never needs more than 16 bits
  localparam int OFF_W     = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;
  localparam int POS_W     = OFF_W + 1;
  localparam int LEN_LIMIT = (1 << OFF_W) - 1;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int LEN_W     = 16;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;

  typedef enum logic [1:0] {
    LIT_TRUE,
    LIT_FALSE,
    LIT_NULL
  } lit_kind_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // text of true, false and null by letter position
  function automatic logic [7:0] lit_char(input lit_kind_t k, input logic [2:0] i);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      LIT_TRUE: begin
        case (i)
          3'd0:    ch = 8'h74;
          3'd1:    ch = 8'h72;
          3'd2:    ch = 8'h75;
          3'd3:    ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        case (i)
          3'd0:    ch = 8'h66;
          3'd1:    ch = 8'h61;
          3'd2:    ch = 8'h6C;
          3'd3:    ch = 8'h73;
          3'd4:    ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      LIT_NULL: begin
        case (i)
          3'd0:    ch = 8'h6E;
          3'd1:    ch = 8'h75;
          3'd2:    ch = 8'h6C;
          3'd3:    ch = 8'h6C;
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] lit_len(input lit_kind_t k);
    logic [2:0] n;
    case (k)
      LIT_FALSE: n = 3'd5;
      default:   n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

// ===== design/jves_in_if.sv =====
// byte input channel of the json value extent scanner
// no dependencies
interface jves_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  logic       last;

  modport source(output valid, data_byte, first, last, input ready);
  modport sink(input valid, data_byte, first, last, output ready);
endinterface

// ===== design/jves_out_if.sv =====
// result channel of the json value extent scanner
// no dependencies
interface jves_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [15:0] value_length;

  modport source(output valid, status, value_length, input ready);
  modport sink(input valid, status, value_length, output ready);
endinterface

// ===== design/json_value_extent_scanner.sv =====
// json value extent scanner: finds the end of one json value and checks its form
// depends on jves_pkg, jves_in_if, jves_out_if
//
// usage
// - in_ch carries one byte per beat; first marks the value's opening byte and
//   clears the scanner, last marks the final byte of the buffer
// - out_ch carries at most one result per value: status 0 with the length just
//   past the value, or status 1 with the error position
// - bytes before any first beat, or after a result, are dropped silently
// timing
// - every byte updates mode, depth and offset in the cycle it is accepted, so
//   one byte is taken per cycle, back to back, while the skid entry is not full
// - a result is registered on out_ch, or in the skid entry while out_ch stalls
// stall
// - an output register plus one skid entry hold results; in_ch.ready drops only
//   while the skid entry is full, so input keeps flowing past a stalled result
// reset
// - rst (synchronous) returns to idle waiting for a first byte and empties
//   both result slots
module json_value_extent_scanner
  import jves_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  jves_in_if.sink     in_ch,
  jves_out_if.source  out_ch
);

  typedef enum logic [4:0] {
    M_IDLE,
    M_DONE,
    M_STR,
    M_SESC,
    M_CON,
    M_CSTR,
    M_CESC,
    M_LTRUE,
    M_LFALSE,
    M_LNULL,
    M_NMINUS,
    M_NZERO,
    M_NINT,
    M_NDOT,
    M_NFRAC,
    M_NEXP,
    M_NESIGN,
    M_NEXPD
  } mode_t;

  // scanner state
  mode_t              mode, mode_next;
  logic [DEPTH_W-1:0] depth, depth_next;
  logic [OFF_W-1:0]   offset, offset_next;
  logic [2:0]         lit_idx, lit_idx_next;

  // result slots: output register and skid entry
  logic             out_valid;
  logic             out_status;
  logic [LEN_W-1:0] out_length;
  logic             skid_valid;
  logic             skid_status;
  logic [LEN_W-1:0] skid_length;

  logic             accept;
  logic [7:0]       c;
  logic [OFF_W-1:0] base_off;
  logic [POS_W-1:0] pos_here, pos_plus1, pos_plus2;
  logic             active;
  logic             hit;
  logic             hit_err;
  logic [POS_W-1:0] hit_pos;
  lit_kind_t        kind;
  logic [7:0]       lit_expect;
  logic [2:0]       lit_total;
  logic             res_status;
  logic [LEN_W-1:0] res_length;
  logic             out_free;

  assign accept   = in_ch.valid && in_ch.ready;
  assign c        = in_ch.data_byte;
  assign base_off = in_ch.first ? '0 : offset;
  assign pos_here  = POS_W'(base_off);
  assign pos_plus1 = POS_W'(base_off) + POS_W'(1);
  assign pos_plus2 = POS_W'(base_off) + POS_W'(2);

  always_comb begin
    case (mode)
      M_LFALSE: kind = LIT_FALSE;
      M_LNULL:  kind = LIT_NULL;
      default:  kind = LIT_TRUE;
    endcase
  end

  assign lit_expect = lit_char(kind, lit_idx);
  assign lit_total  = lit_len(kind);

  // one byte of the scan: start or advance, then buffer end and offset limit
  always_comb begin
    mode_next    = mode;
    depth_next   = depth;
    offset_next  = offset;
    lit_idx_next = lit_idx;
    active       = 1'b0;
    hit          = 1'b0;
    hit_err      = 1'b0;
    hit_pos      = '0;
    if (accept) begin
      if (in_ch.first) begin
        active       = 1'b1;
        depth_next   = '0;
        offset_next  = '0;
        lit_idx_next = '0;
        case (c)
          CH_QUOTE:  mode_next = M_STR;
          CH_LBRACE,
          CH_LBRACK: begin
            mode_next  = M_CON;
            depth_next = DEPTH_W'(1);
          end
          CH_LOW_T: begin
            mode_next    = M_LTRUE;
            lit_idx_next = 3'd1;
          end
          CH_LOW_F: begin
            mode_next    = M_LFALSE;
            lit_idx_next = 3'd1;
          end
          CH_LOW_N: begin
            mode_next    = M_LNULL;
            lit_idx_next = 3'd1;
          end
          CH_MINUS:  mode_next = M_NMINUS;
          CH_ZERO:   mode_next = M_NZERO;
          default: begin
            if (is_digit(c)) begin
              mode_next = M_NINT;
            end else begin
              hit     = 1'b1;
              hit_err = 1'b1;
            end
          end
        endcase
      end else if (mode != M_IDLE && mode != M_DONE) begin
        active = 1'b1;
        case (mode)
          M_STR: begin
            if (c == CH_QUOTE) begin
              hit     = 1'b1;
              hit_pos = pos_plus1;
            end else if (c == CH_BSLASH) begin
              mode_next = M_SESC;
            end
          end
          M_SESC: mode_next = M_STR;
          M_CON: begin
            if (c == CH_LBRACE || c == CH_LBRACK) begin
              if (depth >= DEPTH_W'(MAX_DEPTH)) begin
                hit     = 1'b1;
                hit_err = 1'b1;
                hit_pos = pos_here;
              end else begin
                depth_next = depth + DEPTH_W'(1);
              end
            end else if (c == CH_RBRACE || c == CH_RBRACK) begin
              depth_next = depth - DEPTH_W'(1);
              if (depth == DEPTH_W'(1)) begin
                hit     = 1'b1;
                hit_pos = pos_plus1;
              end
            end else if (c == CH_QUOTE) begin
              mode_next = M_CSTR;
            end
          end
          M_CSTR: begin
            if (c == CH_QUOTE) begin
              mode_next = M_CON;
            end else if (c == CH_BSLASH) begin
              mode_next = M_CESC;
            end
          end
          M_CESC: mode_next = M_CSTR;
          M_LTRUE, M_LFALSE, M_LNULL: begin
            if (lit_idx >= lit_total || c != lit_expect) begin
              hit     = 1'b1;
              hit_err = 1'b1;
            end else begin
              lit_idx_next = lit_idx + 3'd1;
              if (lit_idx + 3'd1 == lit_total) begin
                hit     = 1'b1;
                hit_pos = pos_plus1;
              end
            end
          end
          M_NMINUS: begin
            if (c == CH_ZERO) begin
              mode_next = M_NZERO;
            end else if (is_digit(c)) begin
              mode_next = M_NINT;
            end else begin
              hit     = 1'b1;
              hit_err = 1'b1;
              hit_pos = pos_here;
            end
          end
          M_NZERO, M_NINT, M_NFRAC: begin
            if (is_digit(c) && mode != M_NZERO) begin
              mode_next = mode;
            end else if (c == CH_DOT && mode != M_NFRAC) begin
              mode_next = M_NDOT;
            end else if (c == CH_LOW_E || c == CH_UP_E) begin
              mode_next = M_NEXP;
            end else begin
              // terminating byte is not part of the number
              hit     = 1'b1;
              hit_pos = pos_here;
            end
          end
          M_NDOT: begin
            if (is_digit(c)) begin
              mode_next = M_NFRAC;
            end else begin
              hit     = 1'b1;
              hit_err = 1'b1;
              hit_pos = pos_here;
            end
          end
          M_NEXP: begin
            if (c == CH_PLUS || c == CH_MINUS) begin
              mode_next = M_NESIGN;
            end else if (is_digit(c)) begin
              mode_next = M_NEXPD;
            end else begin
              hit     = 1'b1;
              hit_err = 1'b1;
              hit_pos = pos_here;
            end
          end
          M_NESIGN: begin
            if (is_digit(c)) begin
              mode_next = M_NEXPD;
            end else begin
              hit     = 1'b1;
              hit_err = 1'b1;
              hit_pos = pos_here;
            end
          end
          M_NEXPD: begin
            if (!is_digit(c)) begin
              hit     = 1'b1;
              hit_pos = pos_here;
            end
          end
          default: active = 1'b0;
        endcase
      end

      // buffer end closes whatever is still open, judged on the new mode
      if (active && !hit) begin
        if (in_ch.last) begin
          hit = 1'b1;
          case (mode_next)
            M_NZERO, M_NINT, M_NFRAC, M_NEXPD: hit_pos = pos_plus1;
            M_SESC, M_CESC: begin
              hit_err = 1'b1;
              hit_pos = pos_plus2;
            end
            M_LTRUE, M_LFALSE, M_LNULL: begin
              hit_err = 1'b1;
              hit_pos = '0;
            end
            default: begin
              hit_err = 1'b1;
              hit_pos = pos_plus1;
            end
          endcase
        end else if (base_off >= OFF_W'(LEN_LIMIT)) begin
          hit     = 1'b1;
          hit_err = 1'b1;
          hit_pos = POS_W'(LEN_LIMIT);
        end else begin
          offset_next = base_off + OFF_W'(1);
        end
      end

      if (hit) begin
        mode_next = M_DONE;
      end
    end
  end

  // positions past the length limit turn into an error at the limit
  always_comb begin
    if (hit_pos > POS_W'(LEN_LIMIT)) begin
      res_status = 1'b1;
      res_length = LEN_W'(LEN_LIMIT);
    end else begin
      res_status = hit_err;
      res_length = LEN_W'(hit_pos);
    end
  end

  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      depth      <= '0;
      offset     <= '0;
      lit_idx    <= '0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      mode    <= mode_next;
      depth   <= depth_next;
      offset  <= offset_next;
      lit_idx <= lit_idx_next;
      if (out_free) begin
        if (skid_valid) begin
          // input is held off while skid is full, so no new result here
          out_valid  <= 1'b1;
          out_status <= skid_status;
          out_length <= skid_length;
          skid_valid <= 1'b0;
        end else begin
          out_valid  <= hit;
          out_status <= res_status;
          out_length <= res_length;
        end
      end else if (hit) begin
        skid_valid  <= 1'b1;
        skid_status <= res_status;
        skid_length <= res_length;
      end
    end
  end

  assign in_ch.ready         = !skid_valid;
  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_status;
  assign out_ch.value_length = out_length;

endmodule

// ===== design/jves_checker.sv =====
// port-level checks for the json value extent scanner, bound to its top level
// depends on jves_pkg and json_value_extent_scanner_assert.svh
`include "json_value_extent_scanner_assert.svh"

module jves_checker
  import jves_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_status,
  input logic [LEN_W-1:0] out_length
);

  // a stalled result beat is neither dropped nor changed
  `JVES_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped while stalled")
  `JVES_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_status) && $stable(out_length), "stalled result changed")
  // input stalls only while a result is backed up behind the output
  `JVES_ASSERT(a_ready_backed, !in_ready |-> out_valid, "input stalled with no pending result")
  // reset empties the result slots
  `JVES_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid && in_ready, "result slots not empty after reset")

endmodule

bind json_value_extent_scanner jves_checker u_jves_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_length (out_ch.value_length)
);
